### rtl/multiply_rotate_dice_rng_core_macros.svh
// Assertion macros shared by the dice generator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MULTIPLY_ROTATE_DICE_RNG_CORE_MACROS_SVH
`define MULTIPLY_ROTATE_DICE_RNG_CORE_MACROS_SVH

// antecedent true implies consequent in the same cycle
`define MRDR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent true implies consequent in the next cycle
`define MRDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mrdr_pkg.sv
// Shared types, constants and the seed update function for the dice generator.
// No dependencies.
package mrdr_pkg;

    localparam int DATA_W       = 32;
    localparam int ITER_W       = $clog2(DATA_W);
    localparam int ADDR_W       = 3;
    localparam int REG_IDX_W    = ADDR_W - 2;
    localparam int MAX_DICE_DEF = 255;
    localparam int ROT_R        = 13;

    localparam logic [DATA_W-1:0]    SEED_MULT        = 32'hDEAD_BF03;
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_SEED = '0;

    localparam logic OP_DICE  = 1'b0;
    localparam logic OP_RANGE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    // increment, multiply, then rotate right
    function automatic logic [DATA_W-1:0] next_seed(input logic [DATA_W-1:0] seed);
        logic [DATA_W-1:0] prod;
        prod = SEED_MULT * (seed + DATA_W'(1));
        return {prod[ROT_R-1:0], prod[DATA_W-1:ROT_R]};
    endfunction

endpackage

### rtl/mrdr_mod_unit.sv
// Bit-serial restoring modulo unit: one remainder bit per cycle.
// Depends on mrdr_pkg.
module mrdr_mod_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mrdr_pkg::DATA_W-1:0] i_dividend,
    input  logic [mrdr_pkg::DATA_W-1:0] i_divisor,
    output logic [mrdr_pkg::DATA_W-1:0] o_remainder,
    output mrdr_pkg::t_div_status       o_status
);

    logic [mrdr_pkg::DATA_W-1:0] r_rem;
    logic [mrdr_pkg::DATA_W-1:0] r_dvd;
    logic [mrdr_pkg::DATA_W-1:0] r_dvs;
    logic [mrdr_pkg::ITER_W-1:0] r_iter;
    logic                        r_busy;
    logic                        r_done;
    logic [mrdr_pkg::DATA_W:0]   w_shift;
    logic [mrdr_pkg::DATA_W:0]   w_diff;

    assign w_shift = {r_rem, r_dvd[mrdr_pkg::DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                // keep the shifted value when the trial subtract goes negative
                r_rem  <= w_diff[mrdr_pkg::DATA_W] ? w_shift[mrdr_pkg::DATA_W-1:0]
                                                   : w_diff[mrdr_pkg::DATA_W-1:0];
                r_dvd  <= {r_dvd[mrdr_pkg::DATA_W-2:0], 1'b0};
                r_iter <= r_iter + mrdr_pkg::ITER_W'(1);
                if (r_iter == mrdr_pkg::ITER_W'(mrdr_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_remainder   = r_rem;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

### rtl/multiply_rotate_dice_rng_core.sv
// Multiply-rotate dice generator, top level: sequencer, seed, accumulator, APB.
// Depends on mrdr_pkg, mrdr_mod_unit and the assertion macro header.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | to core   | i_in_valid / o_in_stall  | operation, dice_count, pips, range_*
//  out     | from core | o_out_valid / i_out_stall| value
//  cfg     | to core   | APB psel/penable/pready  | initial_seed at byte address 0
//
// Each die is a seed update, a divider start and the wait in the modulo unit.
// An item rolls n dice (n = 1 for a range); zero pips, zero dice or a zero span roll none.
// The bit-serial modulo unit does the reduction; dice are rolled one after another.
// Synchronous active-low reset clears the seed to zero; no clearing pass.
// o_in_stall is high from acceptance until the result is loaded in the output register;
// a held result blocks only the final load, not the next acceptance.
`include "multiply_rotate_dice_rng_core_macros.svh"

module multiply_rotate_dice_rng_core #(
    parameter int MAX_DICE = mrdr_pkg::MAX_DICE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic [7:0]                  i_dice_count,
    input  logic [mrdr_pkg::DATA_W-1:0] i_pips,
    input  logic [mrdr_pkg::DATA_W-1:0] i_range_low,
    input  logic [mrdr_pkg::DATA_W-1:0] i_range_high,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mrdr_pkg::DATA_W-1:0] o_value,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mrdr_pkg::ADDR_W-1:0] paddr,
    input  logic [mrdr_pkg::DATA_W-1:0] pwdata,
    output logic [mrdr_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int CNT_W = $clog2(MAX_DICE + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_START,
        S_WAIT,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [mrdr_pkg::DATA_W-1:0] r_seed;
    logic [mrdr_pkg::DATA_W-1:0] r_cfg_seed;
    logic [mrdr_pkg::DATA_W-1:0] r_acc;
    logic [mrdr_pkg::DATA_W-1:0] r_faces;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_out_valid;
    logic [mrdr_pkg::DATA_W-1:0] r_value;

    logic                        w_in_acc;
    logic                        w_cfg_wr;
    logic                        w_seed_sel;
    logic                        w_dice_sat;
    logic [CNT_W-1:0]            w_dice_n;
    logic [mrdr_pkg::DATA_W-1:0] w_span;
    logic [mrdr_pkg::DATA_W-1:0] w_rem;
    mrdr_pkg::t_div_status       w_div_sts;

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_seed_sel = (paddr[mrdr_pkg::ADDR_W-1:2] == mrdr_pkg::REG_INITIAL_SEED);
    assign w_cfg_wr   = psel && penable && pwrite && w_seed_sel;
    assign w_dice_sat = (32'(i_dice_count) > 32'(MAX_DICE));
    assign w_dice_n   = w_dice_sat ? CNT_W'(MAX_DICE) : CNT_W'(i_dice_count);
    assign w_span     = i_range_high - i_range_low + mrdr_pkg::DATA_W'(1);

    mrdr_mod_unit u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == S_START),
        .i_dividend  (r_seed),
        .i_divisor   (r_faces),
        .o_remainder (w_rem),
        .o_status    (w_div_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= '0;
            r_cfg_seed  <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (w_cfg_wr) begin
                r_seed     <= pwdata;
                r_cfg_seed <= pwdata;
            end
            // load of a new beat wins over the drain of the old one
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_operation == mrdr_pkg::OP_RANGE) begin
                            r_faces <= w_span;
                            r_cnt   <= CNT_W'(1);
                            r_acc   <= i_range_low - mrdr_pkg::DATA_W'(1);
                            r_state <= (w_span == '0) ? S_DONE : S_STEP;
                        end else begin
                            r_faces <= i_pips;
                            r_cnt   <= w_dice_n;
                            r_acc   <= '0;
                            r_state <= (i_pips == '0 || w_dice_n == '0) ? S_DONE : S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    r_seed  <= mrdr_pkg::next_seed(r_seed);
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_div_sts.done) begin
                        r_acc <= r_acc + w_rem + mrdr_pkg::DATA_W'(1);
                        r_cnt <= r_cnt - CNT_W'(1);
                        r_state <= (r_cnt == CNT_W'(1)) ? S_DONE : S_STEP;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_value     <= r_acc;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign prdata      = w_seed_sel ? r_cfg_seed : '0;
    assign pready      = 1'b1;

    `MRDR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "core not busy after accepting a beat")
    `MRDR_ASSERT_SAME(a_div_done_in_wait, i_clk, i_rst_n, w_div_sts.done, r_state == S_WAIT, "modulo result outside wait state")
    `MRDR_ASSERT_NEXT(a_seed_held_in_div, i_clk, i_rst_n, r_state == S_WAIT && !w_cfg_wr, $stable(r_seed), "seed moved during modulo")
    `MRDR_ASSERT_SAME(a_out_from_done, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state == S_DONE), "result beat without finished item")

endmodule

### bench/tb_multiply_rotate_dice_rng_core.sv
// Self-checking bench for the multiply-rotate dice generator core.
// Predicts each dice sum or ranged value, seeds through the APB port, checks every beat.
// Depends on mrdr_pkg and multiply_rotate_dice_rng_core.
`timescale 1ns / 1ps

module tb_multiply_rotate_dice_rng_core;

    localparam int                          MAX_DICE    = mrdr_pkg::MAX_DICE_DEF;
    localparam logic [31:0]                 ROLL_MULT   = 32'hDEAD_BF03;
    localparam int                          ROT_RIGHT   = 13;
    localparam logic [mrdr_pkg::ADDR_W-1:0] SEED_ADDR   = {mrdr_pkg::REG_INITIAL_SEED, 2'b00};
    localparam int                          QUIET_LIMIT = 40000;
    localparam int                          END_WAIT    = 100;
    localparam int                          MAX_REPORTS = 50;

    typedef struct packed {
        logic        op;
        logic [7:0]  count;
        logic [31:0] pips;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_roll_req;

    logic                        i_clk        = 1'b0;
    logic                        i_rst_n      = 1'b0;
    logic                        i_in_valid   = 1'b0;
    logic                        o_in_stall;
    logic                        i_operation  = mrdr_pkg::OP_DICE;
    logic [7:0]                  i_dice_count = '0;
    logic [mrdr_pkg::DATA_W-1:0] i_pips       = '0;
    logic [mrdr_pkg::DATA_W-1:0] i_range_low  = '0;
    logic [mrdr_pkg::DATA_W-1:0] i_range_high = '0;
    logic                        o_out_valid;
    logic                        i_out_stall  = 1'b0;
    logic [mrdr_pkg::DATA_W-1:0] o_value;
    logic                        psel         = 1'b0;
    logic                        penable      = 1'b0;
    logic                        pwrite       = 1'b0;
    logic [mrdr_pkg::ADDR_W-1:0] paddr        = '0;
    logic [mrdr_pkg::DATA_W-1:0] pwdata       = '0;
    logic [mrdr_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    logic [31:0] seed_model = '0;
    logic [31:0] pending_values[$];
    int          mismatches    = 0;
    int          send_idle_pct = 0;
    int          out_stall_pct = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;

    multiply_rotate_dice_rng_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_dice_count (i_dice_count),
        .i_pips       (i_pips),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial forever #5 i_clk = ~i_clk;

    // one die: advance the seed, reduce by the face count; zero faces leaves the seed alone
    function automatic logic [31:0] roll_die(input logic [31:0] faces);
        logic [31:0] prod;
        if (faces == '0) return '0;
        prod = ROLL_MULT * (seed_model + 32'd1);
        seed_model = {prod[ROT_RIGHT-1:0], prod[31:ROT_RIGHT]};
        return (seed_model % faces) + 32'd1;
    endfunction

    function automatic logic [31:0] predict_value(input t_roll_req r);
        logic [31:0] total;
        int          dice;
        total = '0;
        if (r.op == mrdr_pkg::OP_DICE) begin
            dice = (int'(r.count) > MAX_DICE) ? MAX_DICE : int'(r.count);
            for (int k = 0; k < dice; k++) total += roll_die(r.pips);
        end else begin
            total = r.lo + roll_die(r.hi - r.lo + 32'd1) - 32'd1;
        end
        return total;
    endfunction

    function automatic t_roll_req roll_req(input logic op, input logic [7:0] count,
                                           input logic [31:0] pips, input logic [31:0] lo,
                                           input logic [31:0] hi);
        t_roll_req r;
        r.op    = op;
        r.count = count;
        r.pips  = pips;
        r.lo    = lo;
        r.hi    = hi;
        return r;
    endfunction

    function automatic t_roll_req random_roll();
        t_roll_req r;
        int        pick;
        r.op = ($urandom_range(1) == 0) ? mrdr_pkg::OP_DICE : mrdr_pkg::OP_RANGE;
        // mostly a handful of dice; a few long rolls reach the high count bits
        pick = $urandom_range(99);
        if (pick < 2)
            r.count = 8'($urandom);
        else if (pick < 12)
            r.count = 8'($urandom_range(31, 7));
        else
            r.count = 8'($urandom_range(6));
        case ($urandom_range(7))
            0: r.pips = '0;
            1: r.pips = $urandom_range(20, 1);
            2: r.pips = 32'd1 << $urandom_range(31);
            3: r.pips = 32'hFFFF_FFFF - $urandom_range(15);
            default: r.pips = $urandom;
        endcase
        r.lo = $urandom;
        case ($urandom_range(7))
            0: r.hi = $urandom;
            1: r.hi = r.lo;
            2: begin
                r.lo = '0;
                r.hi = 32'hFFFF_FFFF;
            end
            3: r.hi = r.lo - $urandom_range(50, 1);
            default: r.hi = r.lo + $urandom_range(1000);
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t tb: %s: got 0x%h, expected 0x%h", $time, what, got, want);
    endtask

    // valid is left high after the beat so back-to-back items need no re-raise
    task automatic offer_roll(input t_roll_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= r.op;
        i_dice_count <= r.count;
        i_pips       <= r.pips;
        i_range_low  <= r.lo;
        i_range_high <= r.hi;
        do @(posedge i_clk); while (o_in_stall);
        pending_values.push_back(predict_value(r));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_values.size() != 0);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEED_ADDR;
        pwdata  <= seed;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        seed_model = seed;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // output side: check each beat, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_values.size() == 0)
                report_mismatch("value beat with nothing pending", o_value, '0);
            else if (o_value !== pending_values[0])
                report_mismatch("value", o_value, pending_values.pop_front());
            else
                void'(pending_values.pop_front());
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_dice_cases();
        offer_roll(roll_req(mrdr_pkg::OP_DICE, 8'd1, 32'd6, 32'h0, 32'h0));
        offer_roll(roll_req(mrdr_pkg::OP_DICE, 8'd3, 32'd6, 32'hFFFF_FFFF, 32'h0));
        // zero pips and zero dice: result 0, seed holds
        offer_roll(roll_req(mrdr_pkg::OP_DICE, 8'd5, 32'd0, 32'h1234_5678, 32'h9ABC_DEF0));
        offer_roll(roll_req(mrdr_pkg::OP_DICE, 8'd0, 32'd6, 32'h0, 32'hFFFF_FFFF));
        offer_roll(roll_req(mrdr_pkg::OP_DICE, 8'd4, 32'd1, 32'h0, 32'h0));
        offer_roll(roll_req(mrdr_pkg::OP_DICE, 8'd2, 32'hFFFF_FFFF, 32'h0, 32'h0));
        offer_roll(roll_req(mrdr_pkg::OP_DICE, 8'd1, 32'h8000_0000, 32'h0, 32'h0));
        // full count with huge dice: the sum wraps
        offer_roll(roll_req(mrdr_pkg::OP_DICE, 8'd255, 32'hFFFF_FFFF, 32'h0, 32'h0));
        offer_roll(roll_req(mrdr_pkg::OP_DICE, 8'd128, 32'd20, 32'h0, 32'h0));
        drain_results();
    endtask

    task automatic test_range_cases();
        offer_roll(roll_req(mrdr_pkg::OP_RANGE, 8'hFF, 32'hFFFF_FFFF, 32'd1, 32'd6));
        // full range: die size wraps to zero, result is low - 1
        offer_roll(roll_req(mrdr_pkg::OP_RANGE, 8'd0, 32'd0, 32'h0, 32'hFFFF_FFFF));
        offer_roll(roll_req(mrdr_pkg::OP_RANGE, 8'd7, 32'd3, 32'h8000_0000, 32'h7FFF_FFFF));
        offer_roll(roll_req(mrdr_pkg::OP_RANGE, 8'd0, 32'd0, 32'd100, 32'd10));
        offer_roll(roll_req(mrdr_pkg::OP_RANGE, 8'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        offer_roll(roll_req(mrdr_pkg::OP_RANGE, 8'd0, 32'd0, 32'h0, 32'h0));
        offer_roll(roll_req(mrdr_pkg::OP_RANGE, 8'd0, 32'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF));
        offer_roll(roll_req(mrdr_pkg::OP_RANGE, 8'd0, 32'd0, 32'h0000_0001, 32'h0000_0000));
        drain_results();
    endtask

    task automatic test_seed_loads();
        logic [31:0] seeds[4];
        seeds = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000};
        foreach (seeds[s]) begin
            write_seed(seeds[s]);
            offer_roll(roll_req(mrdr_pkg::OP_DICE, 8'd2, 32'd6, 32'h0, 32'h0));
            offer_roll(roll_req(mrdr_pkg::OP_RANGE, 8'd0, 32'd0, 32'd10, 32'd20));
            offer_roll(roll_req(mrdr_pkg::OP_DICE, 8'd1, 32'hFFFF_FFFF, 32'h0, 32'h0));
            drain_results();
        end
    endtask

    task automatic test_random_rolls(input int idle_pct, input int stall_pct, input int items);
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        write_seed($urandom);
        repeat (items) offer_roll(random_roll());
        drain_results();
        send_idle_pct = 0;
        out_stall_pct = 0;
    endtask

    // output held off long enough that the core backs up into its input
    task automatic test_output_holdoff();
        hold_left = 600;
        repeat (10) offer_roll(roll_req(mrdr_pkg::OP_DICE, 8'd1, $urandom, 32'h0, 32'h0));
        drain_results();
        repeat (10) offer_roll(random_roll());
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_dice_cases();
        test_range_cases();
        test_seed_loads();
        test_random_rolls(0, 0, 400);
        test_random_rolls(88, 0, 400);
        test_random_rolls(0, 88, 400);
        test_random_rolls(34, 34, 400);
        test_output_holdoff();
        repeat (END_WAIT) @(posedge i_clk);
        if (pending_values.size() != 0)
            report_mismatch("values never delivered", pending_values.size(), '0);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
